/* rtl/ggx_pkg.sv */
// ggx_pkg: shared types, constants and the cordic angle table for the ggx sampler
// used by ggx_front, ggx_queue, ggx_back and ggx_normal_sampler
package ggx_pkg;

  localparam int DivSteps    = 29;
  localparam int CordicSteps = 20;
  localparam int SqrtSteps   = 16;

  localparam logic [32:0] CordicGain  = 33'd652032874;
  localparam logic [31:0] AlphaSqReset = 32'h0100_0000;
  localparam logic signed [15:0] UnitQ14 = 16'sd16384;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  // one classified item between front and back
  typedef struct packed {
    quad_e       quad;
    logic [13:0] angle;
    logic [16:0] one_minus_b;
    logic [47:0] alpha_sq_b;
  } item_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2FA;
      5'd15: r = 30'h0000517D;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A30;
      5'd19: r = 30'h00000518;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/ggx_front.sv */
// ggx_front: takes commands, holds alpha squared, forms 1-b and alpha^2*b
// depends on ggx_pkg
module ggx_front import ggx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [15:0] azimuth_random_i,
  input  logic [15:0] polar_random_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        q_full_i,
  output logic        hold_o,
  output logic        push_o,
  output item_t       item_o
);

  logic [31:0] alpha_sq_q;
  logic        valid_q;
  item_t       item_q;
  logic        adv;

  assign hold_o = valid_q && q_full_i;
  assign adv    = !hold_o;
  assign push_o = valid_q && !q_full_i;
  assign item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_sq_q <= AlphaSqReset;
    end else if (cfg_we_i) begin
      alpha_sq_q <= cfg_data_i * cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && take_i) begin
      item_q.quad        <= quad_e'(azimuth_random_i[15:14]);
      item_q.angle       <= azimuth_random_i[13:0];
      item_q.one_minus_b <= 17'h10000 - {1'b0, polar_random_i};
      item_q.alpha_sq_b  <= alpha_sq_q * polar_random_i;
    end
  end

endmodule

/* rtl/ggx_queue.sv */
// ggx_queue: two-entry queue of classified items between front and back
// depends on ggx_pkg
module ggx_queue import ggx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  pop_o,
  output item_t item_o
);

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  // back end never stalls, so a stored item is always taken
  assign pop_o  = (cnt_q != 2'd0);
  assign full_o = (cnt_q == 2'd2);
  assign item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_o)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_o);
    end
  end

endmodule

/* rtl/ggx_back.sv */
// ggx_back: pipelined normalize, restoring divider with cordic alongside,
// two square root lanes, scale and clamp; depends on ggx_pkg
module ggx_back import ggx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  item_t              item_i,
  output logic               valid_o,
  output logic signed [15:0] dir_x_o,
  output logic [14:0]        dir_y_o,
  output logic signed [15:0] dir_z_o
);

  // stage 1: full denominator
  logic        v1_q;
  logic [48:0] d1_q;
  logic [40:0] nc1_q;
  quad_e       qd1_q;
  logic [13:0] ang1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    nc1_q  <= {item_i.one_minus_b, 24'h0};
    d1_q   <= {8'h0, item_i.one_minus_b, 24'h0} + {1'b0, item_i.alpha_sq_b};
    qd1_q  <= item_i.quad;
    ang1_q <= item_i.angle;
  end

  // stage 2: shift so the denominator is below 2^34
  logic [3:0]  sh;
  logic [48:0] d_sh;
  logic [40:0] nc_sh;

  always_comb begin
    sh = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (d1_q[33+k]) sh = 4'(k);
    end
    d_sh  = d1_q >> sh;
    nc_sh = nc1_q >> sh;
  end

  logic                dv_q [0:DivSteps];
  logic [34:0]         dr_q [0:DivSteps];
  logic [33:0]         dd_q [0:DivSteps];
  logic [28:0]         dq_q [0:DivSteps];
  logic signed [32:0]  cx_q [0:DivSteps];
  logic signed [32:0]  cy_q [0:DivSteps];
  logic signed [33:0]  cz_q [0:DivSteps];
  quad_e               cq_q [0:DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else         dv_q[0] <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    dr_q[0] <= {1'b0, nc_sh[33:0]};
    dd_q[0] <= d_sh[33:0];
    dq_q[0] <= '0;
    cx_q[0] <= $signed(CordicGain);
    cy_q[0] <= '0;
    cz_q[0] <= $signed({2'b00, ang1_q, 18'h0});
    cq_q[0] <= qd1_q;
  end

  // one quotient bit per stage; one cordic rotation in each of the first CordicSteps stages, the rest hold
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic        ge;
    logic [34:0] rsub;
    assign ge   = dr_q[k] >= {1'b0, dd_q[k]};
    assign rsub = ge ? dr_q[k] - {1'b0, dd_q[k]} : dr_q[k];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k+1] <= 1'b0;
      else         dv_q[k+1] <= dv_q[k];
    end

    always_ff @(posedge clk_i) begin
      dr_q[k+1] <= {rsub[33:0], 1'b0};
      dd_q[k+1] <= dd_q[k];
      dq_q[k+1] <= {dq_q[k][27:0], ge};
      cq_q[k+1] <= cq_q[k];
    end

    if (k < CordicSteps) begin : g_rot
      logic signed [33:0] at;
      assign at = $signed({4'h0, atan_turn(5'(k))});
      always_ff @(posedge clk_i) begin
        if (!cz_q[k][33]) begin
          cx_q[k+1] <= cx_q[k] - (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] + (cx_q[k] >>> k);
          cz_q[k+1] <= cz_q[k] - at;
        end else begin
          cx_q[k+1] <= cx_q[k] + (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] - (cx_q[k] >>> k);
          cz_q[k+1] <= cz_q[k] + at;
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        cx_q[k+1] <= cx_q[k];
        cy_q[k+1] <= cy_q[k];
        cz_q[k+1] <= cz_q[k];
      end
    end
  end

  // square roots of 4*cos^2 (lane 0) and 4*sin^2 (lane 1)
  logic [28:0] c2;
  assign c2 = (dq_q[DivSteps] > 29'h1000_0000) ? 29'h1000_0000 : dq_q[DivSteps];

  logic               sv_v_q [0:SqrtSteps];
  logic [31:0]        sv_q   [0:SqrtSteps][2];
  logic [19:0]        sr_q   [0:SqrtSteps][2];
  logic [15:0]        so_q   [0:SqrtSteps][2];
  logic signed [32:0] sx_q   [0:SqrtSteps];
  logic signed [32:0] sy_q   [0:SqrtSteps];
  quad_e              sq_q   [0:SqrtSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_v_q[0] <= 1'b0;
    else         sv_v_q[0] <= dv_q[DivSteps];
  end

  always_ff @(posedge clk_i) begin
    sv_q[0][0] <= {1'b0, c2, 2'b00};
    sv_q[0][1] <= {1'b0, 29'h1000_0000 - c2, 2'b00};
    sr_q[0][0] <= '0;
    sr_q[0][1] <= '0;
    so_q[0][0] <= '0;
    so_q[0][1] <= '0;
    sx_q[0]    <= cx_q[DivSteps];
    sy_q[0]    <= cy_q[DivSteps];
    sq_q[0]    <= cq_q[DivSteps];
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_v_q[j+1] <= 1'b0;
      else         sv_v_q[j+1] <= sv_v_q[j];
    end

    always_ff @(posedge clk_i) begin
      sx_q[j+1] <= sx_q[j];
      sy_q[j+1] <= sy_q[j];
      sq_q[j+1] <= sq_q[j];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [19:0] cat, trial;
      assign cat   = {sr_q[j][l][17:0], sv_q[j][l][31:30]};
      assign trial = {2'b00, so_q[j][l], 2'b01};
      always_ff @(posedge clk_i) begin
        sv_q[j+1][l] <= {sv_q[j][l][29:0], 2'b00};
        if (cat >= trial) begin
          sr_q[j+1][l] <= cat - trial;
          so_q[j+1][l] <= {so_q[j][l][14:0], 1'b1};
        end else begin
          sr_q[j+1][l] <= cat;
          so_q[j+1][l] <= {so_q[j][l][14:0], 1'b0};
        end
      end
    end
  end

  // quadrant rotation and scale by sin(theta)
  logic [16:0]        cos_r, sin_r;
  logic signed [32:0] cp, sp;
  logic               m_v_q;
  logic signed [48:0] mx_q, mz_q;
  logic [14:0]        my_q;

  assign cos_r = ({1'b0, so_q[SqrtSteps][0]} + 17'd1) >> 1;
  assign sin_r = ({1'b0, so_q[SqrtSteps][1]} + 17'd1) >> 1;

  always_comb begin
    case (sq_q[SqrtSteps])
      QUAD_0:   begin cp = sx_q[SqrtSteps];  sp = sy_q[SqrtSteps];  end
      QUAD_90:  begin cp = -sy_q[SqrtSteps]; sp = sx_q[SqrtSteps];  end
      QUAD_180: begin cp = -sx_q[SqrtSteps]; sp = -sy_q[SqrtSteps]; end
      QUAD_270: begin cp = sy_q[SqrtSteps];  sp = -sx_q[SqrtSteps]; end
      default:  begin cp = sx_q[SqrtSteps];  sp = sy_q[SqrtSteps];  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else         m_v_q <= sv_v_q[SqrtSteps];
  end

  always_ff @(posedge clk_i) begin
    mx_q <= cp * $signed({1'b0, sin_r[14:0]});
    mz_q <= sp * $signed({1'b0, sin_r[14:0]});
    my_q <= cos_r[14:0];
  end

  // round half up, then clamp to one unit
  function automatic logic signed [15:0] round_clamp(input logic signed [48:0] p);
    logic signed [48:0] t;
    t = (p + 49'sd536870912) >>> 30;
    if (t > 49'sd16384)       return UnitQ14;
    else if (t < -49'sd16384) return -UnitQ14;
    else                      return t[15:0];
  endfunction

  logic               o_v_q;
  logic signed [15:0] ox_q, oz_q;
  logic [14:0]        oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_v_q <= 1'b0;
    else         o_v_q <= m_v_q;
  end

  always_ff @(posedge clk_i) begin
    ox_q <= round_clamp(mx_q);
    oz_q <= round_clamp(mz_q);
    oy_q <= my_q;
  end

  assign valid_o = o_v_q;
  assign dir_x_o = ox_q;
  assign dir_y_o = oy_q;
  assign dir_z_o = oz_q;

endmodule

/* rtl/ggx_normal_sampler.sv */
// ggx_normal_sampler: ggx normal distribution importance sampler, top level
// depends on ggx_pkg, ggx_front, ggx_queue, ggx_back
// throughput: one item per cycle; the 29-stage divider sets the depth
// busy_o stays low since the back end drains the queue every cycle
// reset clears all valid bits and sets roughness to 1.0 (alpha^2 = 2^24)
module ggx_normal_sampler import ggx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [15:0]        azimuth_random_i,
  input  logic [15:0]        polar_random_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  output logic               valid_o,
  output logic signed [15:0] dir_x_o,
  output logic [14:0]        dir_y_o,
  output logic signed [15:0] dir_z_o
);

  logic  hold, push, q_full, pop;
  item_t f_item, q_item;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = hold;

  ggx_front u_front (
    .clk_i, .rst_ni,
    .take_i           (start_i && !hold),
    .azimuth_random_i,
    .polar_random_i,
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i,
    .q_full_i         (q_full),
    .hold_o           (hold),
    .push_o           (push),
    .item_o           (f_item)
  );

  ggx_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (push),
    .item_i (f_item),
    .full_o (q_full),
    .pop_o  (pop),
    .item_o (q_item)
  );

  ggx_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i (pop),
    .item_i     (q_item),
    .valid_o,
    .dir_x_o,
    .dir_y_o,
    .dir_z_o
  );

  a_queue_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_full) else $error("queue filled although the back end never stalls");

  a_push_pops_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> pop) else $error("queued item not taken by back end");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> dir_y_o <= 15'd16384) else $error("cos(theta) above one");

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for ggx_normal_sampler, predicts each direction in fixed point
// depends on ggx_pkg and the ggx_normal_sampler rtl
module tb_top;
  import ggx_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic [14:0]        y;
    logic signed [15:0] z;
  } dir_t;

  class dir_scoreboard;
    dir_t pending[$];
    logic [15:0] alpha;
    int mismatches;

    function new();
      alpha = 16'd4096;
      mismatches = 0;
    endfunction

    function automatic longint floor_shr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, bit_q;
      r = 0;
      bit_q = 64'd1 << 62;
      while (bit_q > v) bit_q = bit_q >> 2;
      while (bit_q != 0) begin
        if (v >= r + bit_q) begin
          v = v - (r + bit_q);
          r = (r >> 1) + bit_q;
        end else begin
          r = r >> 1;
        end
        bit_q = bit_q >> 2;
      end
      return r;
    endfunction

    function automatic longint scale_sat(longint trig, longint s);
      longint p;
      p = floor_shr(trig * s + (64'sd1 <<< 29), 30);
      if (p > 16384) p = 16384;
      if (p < -16384) p = -16384;
      return p;
    endfunction

    function automatic dir_t sample_dir(logic [15:0] a, logic [15:0] b);
      logic [63:0] nc, d, c2, cos_t, sin_t;
      longint x, y, z, dx, dy, cp, sp;
      quad_e q;
      dir_t r;
      nc = (64'd65536 - b) << 24;
      d = nc + 64'(alpha) * 64'(alpha) * 64'(b);
      while (d >= (64'd1 << 34)) begin
        d = d >> 1;
        nc = nc >> 1;
      end
      c2 = (nc << 28) / d;
      if (c2 > (64'd1 << 28)) c2 = 64'd1 << 28;
      cos_t = (root64(c2 * 4) + 1) >> 1;
      sin_t = (root64(((64'd1 << 28) - c2) * 4) + 1) >> 1;
      q = quad_e'(a[15:14]);
      z = longint'(a[13:0]) <<< 18;
      x = longint'(CordicGain);
      y = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
        end else begin
          x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
        end
      end
      case (q)
        QUAD_0:   begin cp = x;  sp = y;  end
        QUAD_90:  begin cp = -y; sp = x;  end
        QUAD_180: begin cp = -x; sp = -y; end
        default:  begin cp = y;  sp = -x; end
      endcase
      r.x = 16'(scale_sat(cp, longint'(sin_t)));
      r.y = 15'(cos_t);
      r.z = 16'(scale_sat(sp, longint'(sin_t)));
      return r;
    endfunction

    function void note_input(logic [15:0] a, logic [15:0] b);
      pending.push_back(sample_dir(a, b));
    endfunction

    function void check_result(logic signed [15:0] x, logic [14:0] y, logic signed [15:0] z);
      dir_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d", x, y, z);
        return;
      end
      e = pending.pop_front();
      if (e.x !== x || e.y !== y || e.z !== z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d", e.x, e.y, e.z, x, y, z);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [15:0] azimuth_random_i = '0;
  logic [15:0] polar_random_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic valid_o;
  logic signed [15:0] dir_x_o;
  logic [14:0] dir_y_o;
  logic signed [15:0] dir_z_o;

  dir_scoreboard sb = new();
  int idle_pct;

  ggx_normal_sampler dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(dir_x_o, dir_y_o, dir_z_o);
  end

  // one sample transfer; random idle cycles before it
  task automatic send_sample(logic [15:0] a, logic [15:0] b);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    azimuth_random_i <= a;
    polar_random_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_input(a, b);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_roughness(logic [15:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.alpha = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_samples(int n);
    logic [15:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7, 0))
        0: b = 16'hFFFF - 16'($urandom_range(15, 0));
        1: b = 16'($urandom_range(15, 0));
        default: b = 16'($urandom);
      endcase
      send_sample(16'($urandom), b);
    end
  endtask

  initial begin
    logic [15:0] alphas[7];
    alphas = '{16'd0, 16'd1, 16'd4096, 16'd65535, 16'd256, 16'd12000, 16'd40000};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    idle_pct = 6;
    // directed: field extremes, quadrant edges, zero and near-one polar values
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h4000, 16'h8000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'hC000, 16'h8000);
    send_sample(16'h3FFF, 16'h0001);
    send_sample(16'h7FFF, 16'hFFFE);
    send_sample(16'hBFFF, 16'h5555);
    send_sample(16'h2000, 16'hAAAA);
    set_roughness(16'd0);
    send_sample(16'h1234, 16'hFFFF);
    send_sample(16'h9876, 16'h0000);
    set_roughness(16'd65535);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hE000, 16'h0001);
    send_sample(16'h5A5A, 16'hA5A5);
    for (int p = 0; p < 7; p++) begin
      set_roughness(p == 6 ? 16'($urandom) : alphas[p]);
      idle_pct = (p < 2) ? 6 : (p < 4 ? 75 : 0);
      random_samples(260);
    end
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

/* sim.f */
rtl/ggx_pkg.sv
rtl/ggx_front.sv
rtl/ggx_queue.sv
rtl/ggx_back.sv
rtl/ggx_normal_sampler.sv
bench/tb_top.sv
